[src/dad_pkg.sv]
// ----------------------------------------------------------------------------
// dad_pkg
// Shared types, calendar tables and helper functions for the date adder.
// ----------------------------------------------------------------------------
package dad_pkg;

  localparam int unsigned AddWidth = 16;
  localparam int unsigned OrdWidth = 9;
  localparam logic [13:0] YearMax  = 14'd9999;
  localparam logic [3:0]  MonthMax = 4'd12;

  typedef struct packed {
    logic [4:0]          day;
    logic [3:0]          month;
    logic [13:0]         year;
    logic [AddWidth-1:0] days_to_add;
  } dad_in_t;

  typedef struct packed {
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [13:0] new_year;
    logic        overflow;
  } dad_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_ORD,
    S_SPLIT,
    S_YEAR,
    S_MONTH,
    S_HOLD
  } dad_state_e;

  typedef struct packed {
    logic load;
    logic clamp;
    logic ord;
    logic split;
    logic year;
    logic month;
    logic emit;
  } dad_cmd_t;

  typedef struct packed {
    logic fits;
    logic yr_over;
    logic yr_last;
    logic mo_last;
  } dad_sts_t;

  // Leap test: q = y / 100 by reciprocal (exact for y below 43690).
  function automatic logic leap_year(input logic [13:0] y);
    logic [27:0] prod;
    logic [8:0]  q;
    logic [13:0] qq;
    logic [13:0] hund;
    logic        div100;
    prod   = {14'd0, y} * 28'd5243;
    q      = prod[27:19];
    qq     = {5'd0, q};
    hund   = (qq << 6) + (qq << 5) + (qq << 2);
    div100 = (hund == y);
    return ((y[1:0] == 2'd0) && !div100) || (div100 && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] mo, input logic leap);
    logic [4:0] n;
    case (mo)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [OrdWidth-1:0] days_before(input logic [3:0] mo);
    logic [OrdWidth-1:0] n;
    case (mo)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [OrdWidth-1:0] days_in_year(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

[src/dad_dpath.sv]
// ----------------------------------------------------------------------------
// dad_dpath
// Date adder datapath: operand registers, year and month stepping, result
// register.
// ----------------------------------------------------------------------------
module dad_dpath (
  input  logic              clk_i,
  input  dad_pkg::dad_in_t  in_req_i,
  input  dad_pkg::dad_cmd_t cmd_i,
  output dad_pkg::dad_sts_t sts_o,
  output dad_pkg::dad_out_t out_rsp_o
);
  import dad_pkg::*;

  logic [4:0]          dy_q;
  logic [3:0]          mo_q;
  logic [13:0]         yr_q;
  logic [AddWidth-1:0] add_q;
  logic [OrdWidth-1:0] ord_q;
  logic                ovf_q;
  dad_out_t            out_q;

  logic                lp;
  logic [4:0]          lim;
  logic [4:0]          dy_c;
  logic [OrdWidth-1:0] diy;
  logic [OrdWidth-1:0] rem;
  logic [AddWidth-1:0] rem_x;
  logic [AddWidth-1:0] diy_x;
  logic [4:0]          dim;

  always_comb begin
    lp    = leap_year(yr_q);
    lim   = days_in_month(mo_q, lp);
    dy_c  = (dy_q > lim) ? lim : dy_q;
    diy   = days_in_year(lp);
    rem   = diy - ord_q;
    rem_x = {{(AddWidth-OrdWidth){1'b0}}, rem};
    diy_x = {{(AddWidth-OrdWidth){1'b0}}, diy};
    dim   = days_in_month(mo_q, lp);
    sts_o.fits    = (add_q <= rem_x);
    sts_o.yr_over = (yr_q > YearMax);
    sts_o.yr_last = (add_q <= diy_x);
    sts_o.mo_last = (mo_q == MonthMax) || (ord_q <= {4'd0, dim});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dy_q  <= in_req_i.day;
      mo_q  <= in_req_i.month;
      yr_q  <= in_req_i.year;
      add_q <= in_req_i.days_to_add;
      ovf_q <= 1'b0;
    end else if (cmd_i.clamp) begin
      if (yr_q == 14'd0) begin
        yr_q <= 14'd1;
      end else if (yr_q > YearMax) begin
        yr_q <= YearMax;
      end
      if (mo_q == 4'd0) begin
        mo_q <= 4'd1;
      end else if (mo_q > MonthMax) begin
        mo_q <= MonthMax;
      end
      if (dy_q == 5'd0) begin
        dy_q <= 5'd1;
      end
    end else if (cmd_i.ord) begin
      ord_q <= days_before(mo_q) + {8'd0, lp && (mo_q > 4'd2)} + {4'd0, dy_c};
    end else if (cmd_i.split) begin
      mo_q <= 4'd1;
      if (sts_o.fits) begin
        ord_q <= ord_q + add_q[OrdWidth-1:0];
      end else begin
        add_q <= add_q - rem_x;
        yr_q  <= yr_q + 14'd1;
      end
    end else if (cmd_i.year) begin
      if (sts_o.yr_over) begin
        ovf_q <= 1'b1;
      end else if (sts_o.yr_last) begin
        ord_q <= add_q[OrdWidth-1:0];
      end else begin
        add_q <= add_q - diy_x;
        yr_q  <= yr_q + 14'd1;
      end
    end else if (cmd_i.month) begin
      if (!sts_o.mo_last) begin
        ord_q <= ord_q - {4'd0, dim};
        mo_q  <= mo_q + 4'd1;
      end
    end
    if (cmd_i.emit) begin
      out_q.new_day   <= ovf_q ? 5'd31 : ord_q[4:0];
      out_q.new_month <= ovf_q ? MonthMax : mo_q;
      out_q.new_year  <= ovf_q ? YearMax : yr_q;
      out_q.overflow  <= ovf_q;
    end
  end

  assign out_rsp_o = out_q;

endmodule

[src/dad_ctrl.sv]
// ----------------------------------------------------------------------------
// dad_ctrl
// Date adder sequencer: walks setup, year and month steps, owns the handshakes.
// ----------------------------------------------------------------------------
module dad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dad_pkg::dad_cmd_t cmd_o,
  input  dad_pkg::dad_sts_t sts_i
);
  import dad_pkg::*;

  dad_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: state_d = S_ORD;
      S_ORD:   state_d = S_SPLIT;
      S_SPLIT: state_d = sts_i.fits ? S_MONTH : S_YEAR;
      S_YEAR: begin
        if (sts_i.yr_over) begin
          state_d = S_HOLD;
        end else if (sts_i.yr_last) begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        if (sts_i.mo_last) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CLAMP: cmd_o.clamp = 1'b1;
      S_ORD:   cmd_o.ord   = 1'b1;
      S_SPLIT: cmd_o.split = 1'b1;
      S_YEAR:  cmd_o.year  = 1'b1;
      S_MONTH: cmd_o.month = 1'b1;
      S_HOLD:  cmd_o.emit  = slot_free;
      default: cmd_o       = '0;
    endcase
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CLAMP))
    else $error("accepted request did not start setup");

  a_over_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_YEAR && sts_i.yr_over) |=> (state_q == S_HOLD))
    else $error("year overflow did not go to result hold");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD && slot_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not presented");

  a_drop_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("result dropped without being taken");
`endif

endmodule

[src/date_add_days.sv]
// Setup (clamp, day of year, split) runs first, then the year loop once the
// count leaves the start year, ending in a final check, then the month walk
// (1 to 12 months, skipped on overflow) and the result register, which waits
// for a free output slot. One request at a time: a new one is taken once the
// result is registered. A 16-bit day count steps about 180 years at most.
// Reset (asynchronous, active low) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// date_add_days
// Adds a day count to a Gregorian date, saturating at 31/12/9999.
// ----------------------------------------------------------------------------
module date_add_days (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dad_pkg::dad_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dad_pkg::dad_out_t out_rsp_o
);
  import dad_pkg::*;

  dad_cmd_t cmd;
  dad_sts_t sts;

  dad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dad_dpath u_dpath (
    .clk_i     (clk_i),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

endmodule
